// ===== hw/rtl/irpdt_pkg.sv =====
// Package: types, constants and helpers for the IR pulse-distance transmitter.
package irpdt_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_REGS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int BYTE_BITS   = 8;
    localparam int FRAME_BITS  = 4 * BYTE_BITS;
    localparam int BITS_W      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_BURST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR   = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_BURST      = 16'd560;
    localparam logic [CFG_DATA_W-1:0] RST_LEAD_MARK  = 16'd9000;
    localparam logic [CFG_DATA_W-1:0] RST_LEAD_SPACE = 16'd4500;
    localparam logic [CFG_DATA_W-1:0] RST_ZERO_SPACE = 16'd560;
    localparam logic [CFG_DATA_W-1:0] RST_ONE_SPACE  = 16'd1690;
    localparam logic [CFG_DATA_W-1:0] RST_DEV_ADDR   = 16'd0;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_LEAD_MARK   = 3'd1,
        PH_LEAD_SPACE  = 3'd2,
        PH_BIT_MARK    = 3'd3,
        PH_BIT_SPACE   = 3'd4,
        PH_STOP_MARK   = 3'd5,
        PH_FINAL_SPACE = 3'd6
    } phase_t;

    typedef struct packed {
        logic line_level;
        logic drive_enable;
        logic busy_res;
        logic frame_done;
    } result_t;

    // Timer load: register value zero-extended or truncated to the timer width.
    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[TIMER_WIDTH-1:0];
    endfunction

endpackage

// ===== hw/rtl/irpdt_if.sv =====
// Interfaces: command channel and result channel of the IR transmitter.
interface irpdt_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] code_byte;

    modport source (output valid, output operation, output code_byte, input ready);
    modport sink   (input valid, input operation, input code_byte, output ready);
endinterface

interface irpdt_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic drive_enable;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output line_level, output drive_enable,
                    output busy_res, output frame_done, input ready);
    modport sink   (input valid, input line_level, input drive_enable,
                    input busy_res, input frame_done, output ready);
endinterface

// ===== hw/rtl/ir_pulse_distance_transmitter_unit.sv =====
// Top level: IR pulse-distance frame transmitter stepped by microsecond ticks.
// Usage: every command transaction gives exactly one result transaction, and
// one command is taken per cycle while ready is high. A command is either a
// one-microsecond tick or a frame start carrying a code byte. A start taken
// while idle latches {~code, code, address} and begins the frame (lead mark,
// lead space, 32 bits LSB first, stop mark, final space); a start while busy
// is ignored. Each tick reports the level of the segment in progress and
// advances a down-counter; a segment of length L lasts max(L,1) ticks. The
// segment state advances in the cycle the command is taken, and its result
// lands in a two-entry output buffer (result register plus skid register), so
// the command side keeps running while one result waits; ready drops only
// when both entries are full. Each result leaves from a register.
// Timing registers are sampled when a segment is entered; the address is
// sampled at frame start. Writes to an index beyond the last register are
// dropped.
module ir_pulse_distance_transmitter_unit
    import irpdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    irpdt_cmd_if.sink             cmd,
    irpdt_res_if.source           res
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] burst_reg, lead_mark_reg, lead_space_reg;
    logic [CFG_DATA_W-1:0] zero_space_reg, one_space_reg, dev_addr_reg;

    // Frame state
    phase_t                 phase_reg, phase_next;
    logic [BITS_W-1:0]      bits_left_reg, bits_left_next;
    logic [TIMER_WIDTH-1:0] ticks_left_reg, ticks_left_next;
    logic [FRAME_BITS-1:0]  frame_shift_reg, frame_shift_next;

    // Output buffer: main result register and a skid register behind it
    result_t main_data_reg, skid_data_reg, res_calc;
    logic    main_valid_reg, skid_valid_reg;

    logic push, pop, busy, seg_end;

    assign cmd.ready = !skid_valid_reg;
    assign push      = cmd.valid && cmd.ready;
    assign pop       = main_valid_reg && res.ready;

    always_comb
    begin
        busy = (phase_reg == PH_LEAD_MARK) || (phase_reg == PH_LEAD_SPACE) ||
               (phase_reg == PH_BIT_MARK) || (phase_reg == PH_BIT_SPACE) ||
               (phase_reg == PH_STOP_MARK) || (phase_reg == PH_FINAL_SPACE);
    end

    assign seg_end = (ticks_left_reg <= TIMER_WIDTH'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg      <= RST_BURST;
            lead_mark_reg  <= RST_LEAD_MARK;
            lead_space_reg <= RST_LEAD_SPACE;
            zero_space_reg <= RST_ZERO_SPACE;
            one_space_reg  <= RST_ONE_SPACE;
            dev_addr_reg   <= RST_DEV_ADDR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BURST:      burst_reg      <= cfg_data;
                REG_LEAD_MARK:  lead_mark_reg  <= cfg_data;
                REG_LEAD_SPACE: lead_space_reg <= cfg_data;
                REG_ZERO_SPACE: zero_space_reg <= cfg_data;
                REG_ONE_SPACE:  one_space_reg  <= cfg_data;
                REG_DEV_ADDR:   dev_addr_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Next-state logic: segment sequencing and down-counter
    always_comb
    begin
        phase_next       = phase_reg;
        bits_left_next   = bits_left_reg;
        ticks_left_next  = ticks_left_reg;
        frame_shift_next = frame_shift_reg;

        if (!busy)
        begin
            phase_next = PH_IDLE;
            if (cmd.operation == OP_START)
            begin
                frame_shift_next = {~cmd.code_byte, cmd.code_byte, dev_addr_reg};
                bits_left_next   = BITS_W'(FRAME_BITS);
                phase_next       = PH_LEAD_MARK;
                ticks_left_next  = timer_load(lead_mark_reg);
            end
        end
        else if (cmd.operation == OP_TICK)
        begin
            if (!seg_end)
            begin
                ticks_left_next = ticks_left_reg - TIMER_WIDTH'(1);
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD_MARK:
                    begin
                        phase_next      = PH_LEAD_SPACE;
                        ticks_left_next = timer_load(lead_space_reg);
                    end
                    PH_LEAD_SPACE:
                    begin
                        phase_next      = PH_BIT_MARK;
                        ticks_left_next = timer_load(burst_reg);
                    end
                    PH_BIT_MARK:
                    begin
                        phase_next      = PH_BIT_SPACE;
                        ticks_left_next = frame_shift_reg[0] ? timer_load(one_space_reg)
                                                             : timer_load(zero_space_reg);
                    end
                    PH_BIT_SPACE:
                    begin
                        frame_shift_next = frame_shift_reg >> 1;
                        ticks_left_next  = timer_load(burst_reg);
                        if (bits_left_reg <= BITS_W'(1))
                        begin
                            bits_left_next = '0;
                            phase_next     = PH_STOP_MARK;
                        end
                        else
                        begin
                            bits_left_next = bits_left_reg - BITS_W'(1);
                            phase_next     = PH_BIT_MARK;
                        end
                    end
                    PH_STOP_MARK:
                    begin
                        phase_next      = PH_FINAL_SPACE;
                        ticks_left_next = timer_load(lead_space_reg);
                    end
                    default:
                    begin
                        // final space over: frame complete
                        phase_next      = PH_IDLE;
                        ticks_left_next = '0;
                    end
                endcase
            end
        end
    end

    // Output logic: result of the transaction being taken
    always_comb
    begin
        res_calc = '{line_level: 1'b1, drive_enable: 1'b0, busy_res: 1'b0, frame_done: 1'b0};
        if (busy)
        begin
            res_calc.line_level   = !((phase_reg == PH_LEAD_MARK) ||
                                      (phase_reg == PH_BIT_MARK) ||
                                      (phase_reg == PH_STOP_MARK));
            res_calc.drive_enable = 1'b1;
            res_calc.busy_res     = 1'b1;
            res_calc.frame_done   = (cmd.operation == OP_TICK) && seg_end &&
                                    (phase_reg == PH_FINAL_SPACE);
        end
        else if (cmd.operation == OP_START)
        begin
            // frame starts in the lead mark
            res_calc.line_level   = 1'b0;
            res_calc.drive_enable = 1'b1;
            res_calc.busy_res     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bits_left_reg   <= '0;
            ticks_left_reg  <= '0;
            frame_shift_reg <= '0;
        end
        else if (push)
        begin
            phase_reg       <= phase_next;
            bits_left_reg   <= bits_left_next;
            ticks_left_reg  <= ticks_left_next;
            frame_shift_reg <= frame_shift_next;
        end
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : res_calc;
        end
        else if (push)
        begin
            skid_data_reg <= res_calc;
        end
    end

    assign res.valid        = main_valid_reg;
    assign res.line_level   = main_data_reg.line_level;
    assign res.drive_enable = main_data_reg.drive_enable;
    assign res.busy_res     = main_data_reg.busy_res;
    assign res.frame_done   = main_data_reg.frame_done;

    // Skid entry only ever sits behind a full result register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty result register");

    // A frame_done result leaves the sequencer idle with a cleared counter
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_calc.frame_done) |=> (phase_reg == PH_IDLE) && (ticks_left_reg == '0))
        else $error("frame_done without return to idle");

    // A start taken while idle always enters the lead mark
    a_start_enters_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !busy && cmd.operation == OP_START) |=>
            (phase_reg == PH_LEAD_MARK) && (bits_left_reg == BITS_W'(FRAME_BITS)))
        else $error("start from idle did not enter lead mark");

    // Line is released whenever the result says not busy
    a_release_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !res_calc.busy_res) |-> (!res_calc.drive_enable && res_calc.line_level))
        else $error("line driven while idle");

endmodule

// ===== dv/ir_pulse_distance_transmitter_unit_test.sv =====
// Testbench: IR pulse-distance transmitter, directed table plus random frames vs. predictor.
module ir_pulse_distance_transmitter_unit_test;
    import irpdt_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS = 1000;      // random transactions that reach the frame logic
    localparam int PHASE_ITEMS  = 200;       // transactions between register updates
    localparam int CYCLE_LIMIT  = 200_000;   // watchdog
    localparam int HOLD_AT      = 300;       // result count that triggers the long hold-off
    localparam int HOLD_CYCLES  = 400;       // length of that hold-off
    localparam int TAIL_CYCLES  = 8;         // quiet cycles after the last result

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = '1;

    // Line states that can be read straight off the frame format
    localparam result_t RES_IDLE  = '{1'b1, 1'b0, 1'b0, 1'b0};
    localparam result_t RES_MARK  = '{1'b0, 1'b1, 1'b1, 1'b0};
    localparam result_t RES_SPACE = '{1'b1, 1'b1, 1'b1, 1'b0};

    typedef enum logic [1:0] {
        STEP_ITEM,   // one command transaction
        STEP_CFG,    // one register write
        STEP_DRAIN   // ticks until the frame in flight has ended
    } step_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half of the time
        RX_THIRD,    // ready a third of the time
        RX_SPARSE    // ready a quarter of the time
    } rx_mode_t;

    typedef struct packed {
        step_kind_t                kind;
        logic                      op;
        logic [7:0]                code;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic                      typed;   // 1: compare against want, not the predictor
        result_t                   want;
    } plan_row_t;

    // Directed part. Rows with typed=1 carry the line state that must come back.
    localparam plan_row_t DIRECTED [30] = '{
        // idle tick straight out of reset
        '{STEP_ITEM,  OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b1, RES_IDLE},
        // short timing, address left at its reset value
        '{STEP_CFG,   OP_TICK,  8'h00, REG_BURST,      16'h0001, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_LEAD_MARK,  16'h0006, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_LEAD_SPACE, 16'h0003, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_ZERO_SPACE, 16'h0001, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_ONE_SPACE,  16'h0002, 1'b0, RES_IDLE},
        // start, start while busy (ignored), lead mark tick
        '{STEP_ITEM,  OP_START, 8'hA5, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_ITEM,  OP_START, 8'h5A, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_ITEM,  OP_TICK,  8'hFF, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_DRAIN, OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b0, RES_IDLE},
        '{STEP_ITEM,  OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b1, RES_IDLE},
        // every segment zero length, address all ones; stray indexes must not alias
        '{STEP_CFG,   OP_TICK,  8'h00, REG_BURST,      16'h0000, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_LEAD_MARK,  16'h0000, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_LEAD_SPACE, 16'h0000, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_ZERO_SPACE, 16'h0000, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_ONE_SPACE,  16'h0000, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_DEV_ADDR,   16'hFFFF, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_PAST_END,   16'h0001, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_TOP,        16'h0001, 1'b0, RES_IDLE},
        // zero-length segments still last one tick each
        '{STEP_ITEM,  OP_START, 8'h00, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_ITEM,  OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_ITEM,  OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b1, RES_SPACE},
        '{STEP_ITEM,  OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_DRAIN, OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b0, RES_IDLE},
        // long lead mark
        '{STEP_CFG,   OP_TICK,  8'h00, REG_LEAD_MARK,  16'h0100, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_BURST,      16'h0001, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_ONE_SPACE,  16'h0002, 1'b0, RES_IDLE},
        '{STEP_CFG,   OP_TICK,  8'h00, REG_DEV_ADDR,   16'h1234, 1'b0, RES_IDLE},
        '{STEP_ITEM,  OP_START, 8'hFF, REG_BURST, 16'h0000, 1'b1, RES_MARK},
        '{STEP_DRAIN, OP_TICK,  8'h00, REG_BURST, 16'h0000, 1'b0, RES_IDLE}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    irpdt_cmd_if cmd_if ();
    irpdt_res_if res_if ();

    ir_pulse_distance_transmitter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // ------------------------------------------------------------------
    // Transmitter model: own copy of registers and frame state
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]  tx_regs [NUM_REGS];
    phase_t                 tx_phase;
    logic [BITS_W-1:0]      tx_bits_left;
    logic [TIMER_WIDTH-1:0] tx_ticks;
    logic [FRAME_BITS-1:0]  tx_frame;

    // Line states still owed by the DUT, oldest first
    result_t pending_line_states [$];

    // Item currently offered on the command channel
    logic    offer_op;
    logic [7:0] offer_code;
    logic    offer_typed;
    result_t offer_want;
    bit      cmd_taken;

    int errors         = 0;
    int results_seen   = 0;
    int frames_sent    = 0;
    int starts_ignored = 0;
    int reg_writes     = 0;
    int random_items   = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    function automatic bit in_mark();
        return tx_phase == PH_LEAD_MARK || tx_phase == PH_BIT_MARK ||
               tx_phase == PH_STOP_MARK;
    endfunction

    // Enter a segment: timer loaded from its register, cut to the timer width
    function automatic void load_segment(phase_t next);
        tx_phase = next;
        case (next)
            PH_LEAD_MARK:                 tx_ticks = TIMER_WIDTH'(tx_regs[REG_LEAD_MARK]);
            PH_LEAD_SPACE, PH_FINAL_SPACE: tx_ticks = TIMER_WIDTH'(tx_regs[REG_LEAD_SPACE]);
            PH_BIT_MARK, PH_STOP_MARK:    tx_ticks = TIMER_WIDTH'(tx_regs[REG_BURST]);
            PH_BIT_SPACE:
                tx_ticks = tx_frame[0] ? TIMER_WIDTH'(tx_regs[REG_ONE_SPACE])
                                       : TIMER_WIDTH'(tx_regs[REG_ZERO_SPACE]);
            default:
            begin
                tx_phase = PH_IDLE;
                tx_ticks = '0;
            end
        endcase
    endfunction

    // Line state produced by one command, and the frame state it leaves behind
    function automatic result_t advance_frame(logic op, logic [7:0] code);
        result_t r;
        r = RES_IDLE;
        if (op == OP_START)
        begin
            // a start while busy changes nothing
            if (tx_phase == PH_IDLE)
            begin
                tx_frame     = {~code, code, tx_regs[REG_DEV_ADDR]};
                tx_bits_left = BITS_W'(FRAME_BITS);
                load_segment(PH_LEAD_MARK);
            end
            r.line_level   = !in_mark();
            r.drive_enable = 1'b1;
            r.busy_res     = 1'b1;
            return r;
        end
        if (tx_phase == PH_IDLE)
            return r;
        r.line_level   = !in_mark();
        r.drive_enable = 1'b1;
        r.busy_res     = 1'b1;
        if (tx_ticks > 1)
        begin
            tx_ticks = tx_ticks - 1'b1;
        end
        else
        begin
            case (tx_phase)
                PH_LEAD_MARK:  load_segment(PH_LEAD_SPACE);
                PH_LEAD_SPACE: load_segment(PH_BIT_MARK);
                PH_BIT_MARK:   load_segment(PH_BIT_SPACE);
                PH_BIT_SPACE:
                begin
                    tx_frame = tx_frame >> 1;
                    if (tx_bits_left <= 1)
                    begin
                        tx_bits_left = '0;
                        load_segment(PH_STOP_MARK);
                    end
                    else
                    begin
                        tx_bits_left = tx_bits_left - 1'b1;
                        load_segment(PH_BIT_MARK);
                    end
                end
                PH_STOP_MARK:  load_segment(PH_FINAL_SPACE);
                default:
                begin
                    // final space over: done pulses with the line still driven high
                    r.frame_done = 1'b1;
                    tx_phase     = PH_IDLE;
                    tx_ticks     = '0;
                    frames_sent++;
                end
            endcase
        end
        return r;
    endfunction

    function automatic void report_field(string name, logic want, logic got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // One clock: check a result transaction, then model a command transaction.
    // Result first, so a line state is always compared against older commands.
    // ------------------------------------------------------------------
    task automatic advance_clock();
        result_t got;
        result_t want;
        @(posedge clk);
        cmd_taken = 1'b0;
        if (res_if.valid && res_if.ready)
        begin
            got.line_level   = res_if.line_level;
            got.drive_enable = res_if.drive_enable;
            got.busy_res     = res_if.busy_res;
            got.frame_done   = res_if.frame_done;
            results_seen++;
            if (pending_line_states.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %b",
                         $time, got);
                errors++;
            end
            else
            begin
                want = pending_line_states.pop_front();
                report_field("line_level",   want.line_level,   got.line_level);
                report_field("drive_enable", want.drive_enable, got.drive_enable);
                report_field("busy_res",     want.busy_res,     got.busy_res);
                report_field("frame_done",   want.frame_done,   got.frame_done);
            end
        end
        if (cmd_if.valid && cmd_if.ready)
        begin
            cmd_taken = 1'b1;
            if (offer_op == OP_START && tx_phase != PH_IDLE)
                starts_ignored++;
            want = advance_frame(offer_op, offer_code);
            pending_line_states.push_back(offer_typed ? offer_want : want);
        end
    endtask

    // Offer one command and hold it until the DUT takes it
    task automatic send_item(logic op, logic [7:0] code, logic typed, result_t want);
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.code_byte <= code;
        offer_op    = op;
        offer_code  = code;
        offer_typed = typed;
        offer_want  = want;
        do
            advance_clock();
        while (!cmd_taken);
    endtask

    // Sender pacing: bursts of back-to-back commands separated by random gaps, some of zero length
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) advance_clock();
            end
        end
    endtask

    // Tick until the model says the frame in flight is over
    task automatic run_to_frame_end();
        while (tx_phase != PH_IDLE)
        begin
            send_item(OP_TICK, 8'($urandom), 1'b0, RES_IDLE);
            pace();
        end
    endtask

    // Stop offering and let every owed result come back before touching registers
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (pending_line_states.size() != 0)
            advance_clock();
        repeat (TAIL_CYCLES) advance_clock();
    endtask

    // Caller lowers cfg_we after the last write of a batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        advance_clock();
        if (idx < NUM_REGS)
            tx_regs[idx] = value;
        reg_writes++;
    endtask

    // Mostly short segments so that many whole frames fit into the run
    function automatic logic [CFG_DATA_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return CFG_DATA_W'($urandom_range(0, 3));
        else if (r < 9)
            return CFG_DATA_W'($urandom_range(4, 12));
        return CFG_DATA_W'($urandom_range(13, 40));
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Watchdog: a hung handshake ends the run here
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results still owed",
                 $time, cycle_count, pending_line_states.size());
        $display("ir_pulse_distance_transmitter_unit_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready follows a mode that changes every stretch; once,
    // it holds off long enough for both output entries to fill so the
    // command channel has to stall.
    // ------------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       hold;
        int       seen;
        int       rx_tick;
        bit       hold_done;
        mode      = RX_OPEN;
        span      = 0;
        hold      = 0;
        seen      = 0;
        rx_tick   = 0;
        hold_done = 1'b0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (res_if.valid && res_if.ready)
                seen++;
            if (seen >= HOLD_AT && !hold_done)
            begin
                hold      = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 160);
                end
                span--;
                case (mode)
                    RX_OPEN:   res_if.ready <= 1'b1;
                    RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                    RX_THIRD:  res_if.ready <= (rx_tick % 3 == 0);
                    default:   res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random phases, each phase opened by
    // a fresh register set written while no result is still owed.
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t row;
        bit        writing;
        logic      op;
        int        n;

        // every input known from time zero
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_TICK;
        cmd_if.code_byte = '0;
        writing          = 1'b0;

        // model reset state
        tx_regs[REG_BURST]      = RST_BURST;
        tx_regs[REG_LEAD_MARK]  = RST_LEAD_MARK;
        tx_regs[REG_LEAD_SPACE] = RST_LEAD_SPACE;
        tx_regs[REG_ZERO_SPACE] = RST_ZERO_SPACE;
        tx_regs[REG_ONE_SPACE]  = RST_ONE_SPACE;
        tx_regs[REG_DEV_ADDR]   = RST_DEV_ADDR;
        tx_phase     = PH_IDLE;
        tx_bits_left = '0;
        tx_ticks     = '0;
        tx_frame     = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: two short frames, then one with a long lead mark; the
        // long hold-off on the result side lands inside that last one.
        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            if (row.kind == STEP_CFG)
            begin
                if (!writing)
                begin
                    settle();
                    writing = 1'b1;
                end
                write_reg(row.idx, row.data);
            end
            else
            begin
                if (writing)
                begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                if (row.kind == STEP_ITEM)
                    send_item(row.op, row.code, row.typed, row.want);
                else
                    run_to_frame_end();
            end
        end

        // Random: mostly well-formed frames (start when idle, then ticks),
        // with stray starts while busy and idle ticks as noise. A phase can
        // end mid-frame, so timing changes also hit a frame in flight.
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            write_reg(REG_BURST,      pick_len());
            write_reg(REG_LEAD_MARK,  pick_len());
            write_reg(REG_LEAD_SPACE, pick_len());
            write_reg(REG_ZERO_SPACE, pick_len());
            write_reg(REG_ONE_SPACE,  pick_len());
            write_reg(REG_DEV_ADDR,   CFG_DATA_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_PAST_END : REG_TOP,
                          CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;
            for (n = 0; n < PHASE_ITEMS && random_items < RANDOM_ITEMS; n++)
            begin
                if (tx_phase == PH_IDLE)
                    op = ($urandom_range(0, 7) != 0) ? OP_START : OP_TICK;
                else
                    op = ($urandom_range(0, 24) == 0) ? OP_START : OP_TICK;
                // a start while busy is dropped by the block; it does not count
                if (!(op == OP_START && tx_phase != PH_IDLE))
                    random_items++;
                send_item(op, 8'($urandom), 1'b0, RES_IDLE);
                pace();
            end
        end

        settle();

        $display("covered %0d complete frames, %0d starts dropped while busy",
                 frames_sent, starts_ignored);
        $display("%0d register writes, %0d line states checked over %0d cycles, %0d mismatches",
                 reg_writes, results_seen, cycle_count, errors);
        if (errors == 0)
            $display("ir_pulse_distance_transmitter_unit_test passed");
        else
            $display("ir_pulse_distance_transmitter_unit_test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/irpdt_pkg.sv
hw/rtl/irpdt_if.sv
hw/rtl/ir_pulse_distance_transmitter_unit.sv
dv/ir_pulse_distance_transmitter_unit_test.sv
